// ===== hw/rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator cell chain.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int VW = 17;

    typedef struct packed {
        logic          valid;
        logic          free;
        logic [VW-1:0] start;
        logic [VW-1:0] size;
    } cell_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INIT,
        OP_ALLOC,
        OP_RELEASE
    } op_kind_t;

    // flag: split for alloc, merge for release
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  idx;
        logic        flag;
    } op_t;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_RESIZE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_RESP
    } state_t;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_NOBLOCK = 2'd2;

endpackage

// ===== hw/rtl/ffha_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_cell
// One table entry; compares locally and shifts with its neighbors.
// ----------------------------------------------------------------------------
module ffha_cell #(
    parameter int IDX          = 0,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ffha_pkg::op_t   op,
    input  ffha_pkg::cell_t left,
    input  ffha_pkg::cell_t right,
    input  logic [15:0]     addr,
    input  logic [15:0]     req,
    output ffha_pkg::cell_t data,
    output logic            fit,
    output logic            match
);

    localparam logic [8:0]               ID   = 9'(IDX);
    localparam logic [ffha_pkg::VW-1:0]  HDR  = ffha_pkg::VW'(HEADER_BYTES);
    localparam logic [ffha_pkg::VW-1:0]  INIT = ffha_pkg::VW'(HEAP_BYTES - HEADER_BYTES);

    ffha_pkg::cell_t cell_reg, cell_next, init_val;
    logic [ffha_pkg::VW-1:0] req_w;
    logic [8:0] op_idx;

    assign req_w  = ffha_pkg::VW'(req);
    assign op_idx = {1'b0, op.idx};

    always_comb begin
        init_val       = '0;
        init_val.valid = (IDX == 0);
        init_val.free  = (IDX == 0);
        init_val.size  = (IDX == 0) ? INIT : '0;
    end

    always_comb begin
        cell_next = cell_reg;
        case (op.kind)
            ffha_pkg::OP_INIT: begin
                cell_next = init_val;
            end
            ffha_pkg::OP_ALLOC: begin
                if (ID == op_idx) begin
                    cell_next.free = 1'b0;
                    if (op.flag) cell_next.size = req_w;
                end else if (op.flag && ID == op_idx + 9'd1) begin
                    cell_next.valid = 1'b1;
                    cell_next.free  = 1'b1;
                    cell_next.start = left.start + HDR + req_w;
                    cell_next.size  = left.size - req_w - HDR;
                end else if (op.flag && ID > op_idx + 9'd1) begin
                    cell_next = left;
                end
            end
            ffha_pkg::OP_RELEASE: begin
                if (ID == op_idx) begin
                    cell_next.free = 1'b1;
                    if (op.flag) cell_next.size = cell_reg.size + HDR + right.size;
                end else if (op.flag && ID > op_idx) begin
                    cell_next = right;
                end
            end
            default: cell_next = cell_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= init_val;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign data  = cell_reg;
    assign fit   = cell_reg.valid && cell_reg.free && (cell_reg.size >= req_w);
    assign match = cell_reg.valid && ((cell_reg.start + HDR) == ffha_pkg::VW'(addr));

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a chain of block cells with split and forward merge.
// ----------------------------------------------------------------------------
// Sequence: accept, scan, apply, respond for each word; a resize that
// moves its block adds a second scan and apply for the release.
// Throughput: one word at a time; the scan/apply sequencer sets the rate.
// Reset: synchronous active-low; table holds one free block spanning the heap.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_address,
    input  logic [15:0] s_request_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_address,
    output logic [1:0]  m_status,
    output logic [15:0] m_copy_bytes
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [ffha_pkg::VW-1:0] HDR = ffha_pkg::VW'(HEADER_BYTES);

    ffha_pkg::state_t state_reg, state_next;
    ffha_pkg::cmd_t   cmd_reg;
    logic [15:0] addr_reg, req_reg;
    logic        phase_reg, phase_next;
    logic [15:0] res_reg, res_next, copy_reg, copy_next;
    logic [1:0]  st_reg, st_next;

    logic          fit_hit_reg, split_reg, match_hit_reg, merge_reg;
    logic [IW-1:0] fit_idx_reg, match_idx_reg;
    logic [15:0]   fit_addr_reg;
    logic [ffha_pkg::VW-1:0] msize_reg;

    ffha_pkg::cell_t cells [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] fit_v, match_v;
    ffha_pkg::op_t op;
    logic move;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            ffha_pkg::cell_t lft, rgt;
            if (g == 0) begin : g_first
                assign lft = '0;
            end else begin : g_mid
                assign lft = cells[g-1];
            end
            if (g == MAX_BLOCKS - 1) begin : g_last
                assign rgt = '0;
            end else begin : g_body
                assign rgt = cells[g+1];
            end
            ffha_cell #(
                .IDX(g), .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .op(op), .left(lft), .right(rgt),
                .addr(addr_reg), .req(req_reg), .data(cells[g]),
                .fit(fit_v[g]), .match(match_v[g])
            );
        end
    endgenerate

    // priority pick, lowest index wins
    logic          f_hit, m_hit, m_merge;
    logic [IW-1:0] f_idx, m_idx;
    logic [ffha_pkg::VW-1:0] f_start, f_size, m_size;

    always_comb begin
        f_hit = 1'b0; f_idx = '0; f_start = '0; f_size = '0;
        m_hit = 1'b0; m_idx = '0; m_size = '0; m_merge = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (fit_v[i]) begin
                f_hit = 1'b1; f_idx = IW'(i);
                f_start = cells[i].start; f_size = cells[i].size;
            end
            if (match_v[i]) begin
                m_hit = 1'b1; m_idx = IW'(i); m_size = cells[i].size;
                m_merge = (i < MAX_BLOCKS - 1) ? (cells[(i+1) % MAX_BLOCKS].valid &&
                                                  cells[(i+1) % MAX_BLOCKS].free) : 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ffha_pkg::S_SCAN) begin
            fit_hit_reg   <= f_hit;
            fit_idx_reg   <= f_idx;
            fit_addr_reg  <= 16'(f_start + HDR);
            split_reg     <= ({1'b0, f_size} >= (18'(req_reg) + 18'(HEADER_BYTES) + 18'd8))
                             && !cells[MAX_BLOCKS-1].valid;
            match_hit_reg <= m_hit;
            match_idx_reg <= m_idx;
            msize_reg     <= m_size;
            merge_reg     <= m_merge;
        end
    end

    always_comb begin
        op = '0;
        op.kind = ffha_pkg::OP_NONE;
        res_next = res_reg; st_next = st_reg; copy_next = copy_reg;
        phase_next = phase_reg;
        move = 1'b0;
        if (state_reg == ffha_pkg::S_APPLY) begin
            if (phase_reg) begin
                op.kind = ffha_pkg::OP_RELEASE;
                op.idx  = 8'(match_idx_reg);
                op.flag = merge_reg;
                phase_next = 1'b0;
            end else begin
                res_next = '0; st_next = ffha_pkg::STAT_DONE; copy_next = '0;
                case (cmd_reg)
                    ffha_pkg::CMD_INIT: op.kind = ffha_pkg::OP_INIT;
                    ffha_pkg::CMD_ALLOC, ffha_pkg::CMD_RELEASE, ffha_pkg::CMD_RESIZE: begin
                        if (cmd_reg == ffha_pkg::CMD_ALLOC ||
                            (cmd_reg == ffha_pkg::CMD_RESIZE && addr_reg == '0)) begin
                            if (fit_hit_reg) begin
                                op.kind = ffha_pkg::OP_ALLOC;
                                op.idx  = 8'(fit_idx_reg);
                                op.flag = split_reg;
                                res_next = fit_addr_reg;
                            end else begin
                                st_next = ffha_pkg::STAT_NOFIT;
                            end
                        end else if (addr_reg == '0) begin
                            st_next = ffha_pkg::STAT_DONE;
                        end else if (!match_hit_reg) begin
                            st_next = ffha_pkg::STAT_NOBLOCK;
                        end else if (cmd_reg == ffha_pkg::CMD_RELEASE || req_reg == '0) begin
                            op.kind = ffha_pkg::OP_RELEASE;
                            op.idx  = 8'(match_idx_reg);
                            op.flag = merge_reg;
                        end else if (msize_reg >= ffha_pkg::VW'(req_reg)) begin
                            res_next = addr_reg;
                        end else if (fit_hit_reg) begin
                            op.kind = ffha_pkg::OP_ALLOC;
                            op.idx  = 8'(fit_idx_reg);
                            op.flag = split_reg;
                            res_next  = fit_addr_reg;
                            copy_next = 16'(msize_reg);
                            phase_next = 1'b1;
                            move = 1'b1;
                        end else begin
                            st_next = ffha_pkg::STAT_NOFIT;
                        end
                    end
                    default: op.kind = ffha_pkg::OP_NONE;
                endcase
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::S_IDLE:  if (s_valid) state_next = ffha_pkg::S_SCAN;
            ffha_pkg::S_SCAN:  state_next = ffha_pkg::S_APPLY;
            ffha_pkg::S_APPLY: state_next = move ? ffha_pkg::S_SCAN : ffha_pkg::S_RESP;
            ffha_pkg::S_RESP:  if (m_ready) state_next = ffha_pkg::S_IDLE;
            default:           state_next = ffha_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::S_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= ffha_pkg::cmd_t'(s_command);
            addr_reg <= s_address;
            req_reg  <= s_request_bytes;
        end
        res_reg  <= res_next;
        st_reg   <= st_next;
        copy_reg <= copy_next;
    end

    assign s_ready          = (state_reg == ffha_pkg::S_IDLE);
    assign m_valid          = (state_reg == ffha_pkg::S_RESP);
    assign m_result_address = res_reg;
    assign m_status         = st_reg;
    assign m_copy_bytes     = copy_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept while result pending");
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cells[0].valid) else $error("first block lost");
    a_phase_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> cmd_reg == ffha_pkg::CMD_RESIZE) else $error("stray move phase");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 2'd3)) else $error("bad status code");

endmodule
